[rtl/core/luhn_pkg.sv]
// Package for the Luhn card number classifier.
// Holds widths, pipeline depths, verdict codes, defaults and the digit weight helper.
package luhn_pkg;

  localparam int CardW = 63;
  localparam int CountW = 5;
  localparam int DefaultMaxDigits = 19;

  // Decimal digits held while converting; a 63-bit value has at most 19
  localparam int BcdDigits = 19;
  localparam int BcdW = 4 * BcdDigits;

  // Binary bits shifted into the decimal register per pipeline stage
  localparam int DabbleBits = 3;
  localparam int DabbleStages = CardW / DabbleBits;

  // Stages after conversion: digit weights, total and class, remainder
  localparam int ScoreStages = 3;
  localparam int LatencyCycles = DabbleStages + ScoreStages;

  // Digits summed together in the first scoring stage
  localparam int GroupDigits = 5;
  localparam int Groups = 4;

  typedef enum logic [1:0] {
    VERDICT_INVALID = 2'd0,
    VERDICT_CLASS_A = 2'd1,
    VERDICT_LEAD4   = 2'd2,
    VERDICT_CLASS_M = 2'd3
  } verdict_t;

  // Weight of one digit: doubled digits of ten or more add their two digits
  function automatic logic [3:0] luhn_weight(input logic [3:0] d, input logic dbl);
    logic [4:0] w;
    w = {1'b0, d};
    if (dbl) begin
      w = {d, 1'b0};
      if (w >= 5'd10) begin
        w = w - 5'd9;
      end
    end
    return w[3:0];
  endfunction

endpackage

[rtl/core/luhn_digit_unit.sv]
// One stage of the binary to decimal conversion: shifts DabbleBits bits of
// the number into the decimal digit register. Depends on luhn_pkg.
module luhn_digit_unit
  import luhn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  logic [CardW-1:0] bin,
  input  logic [BcdW-1:0]  bcd,
  output logic             shifted_valid,
  output logic [CardW-1:0] shifted_bin,
  output logic [BcdW-1:0]  shifted_bcd
);
  logic [CardW-1:0] bin_next;
  logic [BcdW-1:0]  bcd_next;

  // Add three to every digit of five or more, then shift one bit in
  always_comb begin
    bin_next = bin;
    bcd_next = bcd;
    for (int s = 0; s < DabbleBits; s++) begin
      for (int i = 0; i < BcdDigits; i++) begin
        if (bcd_next[4*i +: 4] >= 4'd5) begin
          bcd_next[4*i +: 4] = bcd_next[4*i +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BcdW-2:0], bin_next[CardW-1]};
      bin_next = {bin_next[CardW-2:0], 1'b0};
    end
  end

  // Advance the item one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      shifted_valid <= 1'b0;
    end else begin
      shifted_valid <= valid;
    end
    shifted_bin <= bin_next;
    shifted_bcd <= bcd_next;
  end
endmodule

[rtl/core/luhn_card_number_classifier.sv]
// Luhn card number classifier, top level.
// Depends on luhn_pkg and luhn_digit_unit.
//
// Usage: drive card_number and raise start; an item is taken at every edge
// where start is high and busy is low. busy is high only during reset, so
// items may follow back to back, one per cycle.
// The number is converted to decimal digits in DabbleStages (21) pipeline
// stages of three bits each. Three scoring stages follow: digit weights and
// length, then the weighted total and the length/prefix class, then the
// remainder by ten and the verdict. The result shows on verdict,
// checksum_ok and digit_count with done high for exactly one cycle.
// Throughput is one item per cycle. Valid bits travel with the data; the
// receiver cannot stall, so nothing is held. Synchronous reset drops
// every item in flight and clears done.
module luhn_card_number_classifier
  import luhn_pkg::*;
#(
  parameter int MAX_DIGITS = DefaultMaxDigits
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CardW-1:0] card_number,
  output logic             busy,
  output logic             done,
  output logic [1:0]       verdict,
  output logic             checksum_ok,
  output logic [CountW-1:0] digit_count
);
  logic              accept;
  logic              stage_valid [DabbleStages];
  logic [CardW-1:0]  stage_bin   [DabbleStages];
  logic [BcdW-1:0]   stage_bcd   [DabbleStages];
  logic [BcdW-1:0]   last_bcd;

  logic [3:0]        weight [BcdDigits];
  logic [CountW-1:0] count_next;
  logic [5:0]        part_next [Groups];
  logic              s1_valid;
  logic [CountW-1:0] s1_count;
  logic [5:0]        s1_part [Groups];
  logic [15:0]       s1_lead;

  logic [3:0]        lead12, lead13, lead14, lead15;
  logic [7:0]        total_next;
  verdict_t          class_next;
  logic              s2_valid;
  logic [7:0]        s2_total;
  logic [CountW-1:0] s2_count;
  logic              s2_over;
  verdict_t          s2_class;

  logic [7:0]        rem;
  logic              sum_ok;

  assign busy = rst;
  assign accept = start & ~busy;

  // Convert the number to decimal digits, three bits per stage
  for (genvar j = 0; j < DabbleStages; j++) begin : g_stage
    if (j == 0) begin : g_first
      luhn_digit_unit u_digit (
        .clk(clk), .rst(rst), .valid(accept), .bin(card_number),
        .bcd({BcdW{1'b0}}),
        .shifted_valid(stage_valid[j]), .shifted_bin(stage_bin[j]),
        .shifted_bcd(stage_bcd[j])
      );
    end else begin : g_next
      luhn_digit_unit u_digit (
        .clk(clk), .rst(rst), .valid(stage_valid[j-1]), .bin(stage_bin[j-1]),
        .bcd(stage_bcd[j-1]),
        .shifted_valid(stage_valid[j]), .shifted_bin(stage_bin[j]),
        .shifted_bcd(stage_bcd[j])
      );
    end
  end

  assign last_bcd = stage_bcd[DabbleStages-1];

  // Count digits and weigh every second digit from the right
  always_comb begin
    count_next = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      weight[i] = luhn_weight(last_bcd[4*i +: 4], 1'(i % 2));
      if (last_bcd[4*i +: 4] != 4'd0) begin
        count_next = CountW'(i + 1);
      end
    end
    for (int g = 0; g < Groups; g++) begin
      part_next[g] = '0;
    end
    for (int i = 0; i < BcdDigits; i++) begin
      part_next[i / GroupDigits] = part_next[i / GroupDigits] + {2'b00, weight[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= stage_valid[DabbleStages-1];
    end
    s1_count <= count_next;
    for (int g = 0; g < Groups; g++) begin
      s1_part[g] <= part_next[g];
    end
    s1_lead <= last_bcd[63:48];
  end

  assign lead12 = s1_lead[3:0];
  assign lead13 = s1_lead[7:4];
  assign lead14 = s1_lead[11:8];
  assign lead15 = s1_lead[15:12];

  // Add the group sums and classify by length and leading digits
  always_comb begin
    total_next = '0;
    for (int g = 0; g < Groups; g++) begin
      total_next = total_next + {2'b00, s1_part[g]};
    end
    class_next = VERDICT_INVALID;
    if (s1_count == CountW'(15) && lead14 == 4'd3 && (lead13 == 4'd4 || lead13 == 4'd7)) begin
      class_next = VERDICT_CLASS_A;
    end else if (s1_count == CountW'(13) && lead12 == 4'd4) begin
      class_next = VERDICT_LEAD4;
    end else if (s1_count == CountW'(16) && lead15 == 4'd4) begin
      class_next = VERDICT_LEAD4;
    end else if (s1_count == CountW'(16) && lead15 == 4'd5 && lead14 >= 4'd1 &&
                 lead14 <= 4'd5) begin
      class_next = VERDICT_CLASS_M;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_total <= total_next;
    s2_count <= s1_count;
    s2_over <= s1_count > CountW'(MAX_DIGITS);
    s2_class <= class_next;
  end

  // Reduce the total by ten: subtract 160, 80, 40, 20, 10 where they fit
  always_comb begin
    rem = s2_total;
    if (rem >= 8'd160) rem = rem - 8'd160;
    if (rem >= 8'd80) rem = rem - 8'd80;
    if (rem >= 8'd40) rem = rem - 8'd40;
    if (rem >= 8'd20) rem = rem - 8'd20;
    if (rem >= 8'd10) rem = rem - 8'd10;
    sum_ok = (rem == 8'd0);
  end

  // Show the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    if (s2_over) begin
      verdict <= VERDICT_INVALID;
      checksum_ok <= 1'b0;
      digit_count <= CountW'(MAX_DIGITS);
    end else begin
      verdict <= sum_ok ? s2_class : VERDICT_INVALID;
      checksum_ok <= sum_ok;
      digit_count <= s2_count;
    end
  end
endmodule

[rtl/core/luhn_checker.sv]
// Port-level checks for the Luhn classifier, bound to the top level.
// Depends on luhn_pkg.
module luhn_checker
  import luhn_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [1:0] verdict,
  input logic checksum_ok,
  input logic [CountW-1:0] digit_count
);
  a_busy_reset: assert property (@(posedge clk)
    busy == rst) else $error("busy outside reset");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LatencyCycles done) else $error("result missing");
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LatencyCycles)) else $error("result without item");
  a_bad_sum: assert property (@(posedge clk) disable iff (rst)
    done && !checksum_ok |-> verdict == VERDICT_INVALID)
    else $error("class given with failed checksum");
  a_len: assert property (@(posedge clk) disable iff (rst)
    done && verdict != VERDICT_INVALID |-> digit_count == CountW'(13) ||
    digit_count == CountW'(15) || digit_count == CountW'(16))
    else $error("class with wrong length");
endmodule

bind luhn_card_number_classifier luhn_checker u_luhn_checker (.*);
